>>> rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and codes of the sorted label table
// Request/response structs, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package slt_pkg;

   // Fixed field widths of the request and response
   localparam int TYPE_BITS  = 8;
   localparam int CLASS_LSB  = 4;   // upper nibble of the type byte ranks the class
   localparam int SLOT_BITS  = 10;
   localparam int OCC_BITS   = 11;
   localparam int STAT_BITS  = 3;

   // Operation codes
   localparam logic [1:0] MODE_FIND   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   // Status codes
   localparam logic [STAT_BITS-1:0] STATUS_INSERTED = 3'd0;
   localparam logic [STAT_BITS-1:0] STATUS_UPGRADED = 3'd1;
   localparam logic [STAT_BITS-1:0] STATUS_REUSED   = 3'd2;
   localparam logic [STAT_BITS-1:0] STATUS_FOUND    = 3'd3;
   localparam logic [STAT_BITS-1:0] STATUS_ABSENT   = 3'd4;
   localparam logic [STAT_BITS-1:0] STATUS_REMOVED  = 3'd5;
   localparam logic [STAT_BITS-1:0] STATUS_FULL     = 3'd6;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] address;
      logic [7:0]  label_type;
      logic [7:0]  segment;
   } req_item_type;

   typedef struct packed {
      logic [STAT_BITS-1:0] status;
      logic [SLOT_BITS-1:0] slot;
      logic [7:0]           stored_type;
      logic [7:0]           stored_segment;
      logic [OCC_BITS-1:0]  occupancy;
   } rsp_item_type;

   // Outcome of the shared compare unit
   typedef struct packed {
      logic key_lt;     // stored key below request key
      logic key_eq;     // stored key equals request key
      logic class_gt;   // request type class above stored type class
   } cmp_result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_CMP,
      S_PROBE,
      S_SHIFT_UP,
      S_WRITE_NEW,
      S_SHIFT_DOWN
   } state_type;

endpackage

>>> rtl/core/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module slt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/slt_cmp.sv
// ----------------------------------------------------------------------------
// slt_cmp: shared compare unit
// Compares a stored entry against the request key and type class.
// ----------------------------------------------------------------------------
module slt_cmp #(
   parameter int KEY_BITS = 32
) (
   input  logic [KEY_BITS-1:0]           entry_key,
   input  logic [slt_pkg::TYPE_BITS-1:0] entry_type,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [slt_pkg::TYPE_BITS-1:0] req_type,
   output slt_pkg::cmp_result_type       result
);

   // Key order and type class rank
   always_comb begin
      result.key_lt   = entry_key < req_key;
      result.key_eq   = entry_key == req_key;
      result.class_gt = req_type[slt_pkg::TYPE_BITS-1:slt_pkg::CLASS_LSB] >
                        entry_type[slt_pkg::TYPE_BITS-1:slt_pkg::CLASS_LSB];
   end

endmodule

>>> rtl/core/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl: sequencer of the sorted label table
// Binary search, presence probe and one-entry-per-cycle shifts over the RAM.
// ----------------------------------------------------------------------------
module slt_ctrl #(
   parameter int CAPACITY  = 1024,
   parameter int ADDR_BITS = 32,
   parameter int SEG_BITS  = 8,
   localparam int IW = $clog2(CAPACITY),
   localparam int EW = ADDR_BITS + slt_pkg::TYPE_BITS + SEG_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  slt_pkg::req_item_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output slt_pkg::rsp_item_type rsp_data,
   output logic                  ram_rd_en,
   output logic [IW-1:0]         ram_rd_addr,
   input  logic [EW-1:0]         ram_rd_data,
   output logic                  ram_wr_en,
   output logic [IW-1:0]         ram_wr_addr,
   output logic [EW-1:0]         ram_wr_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int TB = slt_pkg::TYPE_BITS;

   slt_pkg::state_type state_ff, state_in;

   logic [1:0]           mode_ff, mode_in;
   logic [ADDR_BITS-1:0] key_ff, key_in;
   logic [TB-1:0]        type_ff, type_in;
   logic [SEG_BITS-1:0]  seg_ff, seg_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        src_ff, src_in;
   logic [CW-1:0]        total_ff, total_in;
   logic                 probe_hit_ff, probe_hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   slt_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [ADDR_BITS-1:0] ent_key;
   logic [TB-1:0]        ent_type;
   logic [SEG_BITS-1:0]  ent_seg;
   slt_pkg::cmp_result_type cmp;

   logic [CW-1:0] mid;
   logic [CW-1:0] last;
   logic          present;
   logic          full;
   logic          range_open;
   logic          pos_inside;
   logic          more_down;

   // Split the RAM word into its fields
   assign ent_key  = ram_rd_data[EW-1 -: ADDR_BITS];
   assign ent_type = ram_rd_data[SEG_BITS +: TB];
   assign ent_seg  = ram_rd_data[SEG_BITS-1:0];

   slt_cmp #(
      .KEY_BITS(ADDR_BITS)
   ) u_cmp (
      .entry_key (ent_key),
      .entry_type(ent_type),
      .req_key   (key_ff),
      .req_type  (type_ff),
      .result    (cmp)
   );

   // Decision terms shared by both state machine blocks
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last       = total_ff - 1'b1;
   assign present    = probe_hit_ff & cmp.key_eq;
   assign full       = total_ff == CW'(CAPACITY);
   assign range_open = lo_ff < hi_ff;
   assign pos_inside = lo_ff < total_ff;
   assign more_down  = CW'(lo_ff + 1'b1) < total_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slt_pkg::S_IDLE: begin
            if (start) begin
               state_in = slt_pkg::S_SEARCH;
            end
         end
         slt_pkg::S_SEARCH: begin
            state_in = range_open ? slt_pkg::S_SEARCH_CMP : slt_pkg::S_PROBE;
         end
         slt_pkg::S_SEARCH_CMP: begin
            state_in = slt_pkg::S_SEARCH;
         end
         slt_pkg::S_PROBE: begin
            state_in = slt_pkg::S_IDLE;
            if (mode_ff == slt_pkg::MODE_INSERT) begin
               if (!present && !full && pos_inside) begin
                  state_in = slt_pkg::S_SHIFT_UP;
               end
            end else if (mode_ff == slt_pkg::MODE_REMOVE) begin
               if (present && more_down) begin
                  state_in = slt_pkg::S_SHIFT_DOWN;
               end
            end
         end
         slt_pkg::S_SHIFT_UP: begin
            if (src_ff == lo_ff) begin
               state_in = slt_pkg::S_WRITE_NEW;
            end
         end
         slt_pkg::S_WRITE_NEW: begin
            state_in = slt_pkg::S_IDLE;
         end
         slt_pkg::S_SHIFT_DOWN: begin
            if (src_ff == last) begin
               state_in = slt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = slt_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath, RAM commands and response
   always_comb begin
      mode_in      = mode_ff;
      key_in       = key_ff;
      type_in      = type_ff;
      seg_in       = seg_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      src_in       = src_ff;
      total_in     = total_ff;
      probe_hit_in = probe_hit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = IW'(lo_ff);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = IW'(lo_ff);
      ram_wr_data  = ram_rd_data;

      unique case (state_ff)
         slt_pkg::S_IDLE: begin
            // Capture the request and open the full search range
            if (start) begin
               mode_in = req_data.mode;
               key_in  = ADDR_BITS'(req_data.address);
               type_in = req_data.label_type;
               seg_in  = SEG_BITS'(req_data.segment);
               lo_in   = '0;
               hi_in   = total_ff;
            end
         end
         slt_pkg::S_SEARCH: begin
            // Read the midpoint, or probe the lower bound once the range closes
            if (range_open) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IW'(mid);
               src_in      = mid;
            end else begin
               probe_hit_in = pos_inside;
               ram_rd_en    = pos_inside;
               ram_rd_addr  = IW'(lo_ff);
            end
         end
         slt_pkg::S_SEARCH_CMP: begin
            // Narrow the range
            if (cmp.key_lt) begin
               lo_in = CW'(src_ff + 1'b1);
            end else begin
               hi_in = src_ff;
            end
         end
         slt_pkg::S_PROBE: begin
            rsp_in.slot           = slt_pkg::SLOT_BITS'(lo_ff);
            rsp_in.stored_type    = ent_type;
            rsp_in.stored_segment = 8'(ent_seg);
            rsp_in.occupancy      = slt_pkg::OCC_BITS'(total_ff);
            case (mode_ff)
               slt_pkg::MODE_INSERT: begin
                  if (present) begin
                     // Raise the class in place or reuse the entry
                     rsp_valid_in = 1'b1;
                     if (cmp.class_gt) begin
                        ram_wr_en          = 1'b1;
                        ram_wr_data        = {key_ff, type_ff, ent_seg};
                        rsp_in.status      = slt_pkg::STATUS_UPGRADED;
                        rsp_in.stored_type = type_ff;
                     end else begin
                        rsp_in.status = slt_pkg::STATUS_REUSED;
                     end
                  end else if (full) begin
                     rsp_valid_in          = 1'b1;
                     rsp_in.status         = slt_pkg::STATUS_FULL;
                     rsp_in.slot           = '0;
                     rsp_in.stored_type    = '0;
                     rsp_in.stored_segment = '0;
                  end else if (pos_inside) begin
                     // Start the upward shift from the top entry
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = IW'(last);
                     src_in      = last;
                  end else begin
                     // Append at the end
                     ram_wr_en             = 1'b1;
                     ram_wr_data           = {key_ff, type_ff, seg_ff};
                     total_in              = CW'(total_ff + 1'b1);
                     rsp_valid_in          = 1'b1;
                     rsp_in.status         = slt_pkg::STATUS_INSERTED;
                     rsp_in.stored_type    = type_ff;
                     rsp_in.stored_segment = 8'(seg_ff);
                     rsp_in.occupancy      = slt_pkg::OCC_BITS'(total_in);
                  end
               end
               slt_pkg::MODE_REMOVE: begin
                  if (!present) begin
                     rsp_valid_in          = 1'b1;
                     rsp_in.status         = slt_pkg::STATUS_ABSENT;
                     rsp_in.slot           = '0;
                     rsp_in.stored_type    = '0;
                     rsp_in.stored_segment = '0;
                  end else if (more_down) begin
                     // Hold the removed fields and start the downward shift
                     type_in     = ent_type;
                     seg_in      = ent_seg;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = IW'(lo_ff + 1'b1);
                     src_in      = CW'(lo_ff + 1'b1);
                  end else begin
                     total_in         = last;
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = slt_pkg::STATUS_REMOVED;
                     rsp_in.occupancy = slt_pkg::OCC_BITS'(total_in);
                  end
               end
               default: begin
                  // Find, and the unused code
                  rsp_valid_in = 1'b1;
                  if (present) begin
                     rsp_in.status = slt_pkg::STATUS_FOUND;
                  end else begin
                     rsp_in.status         = slt_pkg::STATUS_ABSENT;
                     rsp_in.slot           = '0;
                     rsp_in.stored_type    = '0;
                     rsp_in.stored_segment = '0;
                  end
               end
            endcase
         end
         slt_pkg::S_SHIFT_UP: begin
            // Move one entry up while reading the next one below
            ram_wr_en   = 1'b1;
            ram_wr_addr = IW'(src_ff + 1'b1);
            if (src_ff != lo_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IW'(src_ff - 1'b1);
               src_in      = src_ff - 1'b1;
            end
         end
         slt_pkg::S_WRITE_NEW: begin
            // Drop the new entry into the opened slot
            ram_wr_en             = 1'b1;
            ram_wr_data           = {key_ff, type_ff, seg_ff};
            total_in              = CW'(total_ff + 1'b1);
            rsp_valid_in          = 1'b1;
            rsp_in.status         = slt_pkg::STATUS_INSERTED;
            rsp_in.slot           = slt_pkg::SLOT_BITS'(lo_ff);
            rsp_in.stored_type    = type_ff;
            rsp_in.stored_segment = 8'(seg_ff);
            rsp_in.occupancy      = slt_pkg::OCC_BITS'(total_in);
         end
         slt_pkg::S_SHIFT_DOWN: begin
            // Move one entry down while reading the next one above
            ram_wr_en   = 1'b1;
            ram_wr_addr = IW'(src_ff - 1'b1);
            if (src_ff == last) begin
               total_in              = last;
               rsp_valid_in          = 1'b1;
               rsp_in.status         = slt_pkg::STATUS_REMOVED;
               rsp_in.slot           = slt_pkg::SLOT_BITS'(lo_ff);
               rsp_in.stored_type    = type_ff;
               rsp_in.stored_segment = 8'(seg_ff);
               rsp_in.occupancy      = slt_pkg::OCC_BITS'(total_in);
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IW'(src_ff + 1'b1);
               src_in      = CW'(src_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slt_pkg::S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      type_ff      <= type_in;
      seg_ff       <= seg_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      src_ff       <= src_in;
      probe_hit_ff <= probe_hit_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = state_ff != slt_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/sorted_label_table.sv
// ----------------------------------------------------------------------------
// sorted_label_table: address-sorted label table
// Find, insert-or-upgrade and remove over a RAM kept in ascending key order.
// ----------------------------------------------------------------------------
// A find alternates S_SEARCH and S_SEARCH_CMP over the binary search range, then checks
//   the entry at the lower bound in S_PROBE, which registers the response strobe.
// An insert that shifts moves one entry per cycle in S_SHIFT_UP, then writes the new entry
//   in S_WRITE_NEW; a remove moves one entry per cycle in S_SHIFT_DOWN.
// busy drops in the cycle the response strobe rises; a new request may start then.
// Responses cannot be stalled. Synchronous reset empties the table (count to zero).
module sorted_label_table #(
   parameter int CAPACITY  = 1024,
   parameter int ADDR_BITS = 32,
   parameter int SEG_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  slt_pkg::req_item_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output slt_pkg::rsp_item_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int EW = ADDR_BITS + slt_pkg::TYPE_BITS + SEG_BITS;

   logic          ram_rd_en;
   logic [IW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;
   logic          ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;

   slt_ctrl #(
      .CAPACITY (CAPACITY),
      .ADDR_BITS(ADDR_BITS),
      .SEG_BITS (SEG_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data)
   );

   slt_ram #(
      .WIDTH(EW),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // An accepted request keeps the sequencer busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("sequencer idle after accepting a request");

   // A response only closes a request that was in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   // The table is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !ram_wr_en)
      else $error("RAM write while idle");

   // Full status only when the table holds CAPACITY entries
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == slt_pkg::STATUS_FULL)
      |-> rsp_data.occupancy == slt_pkg::OCC_BITS'(CAPACITY))
      else $error("full status with free slots");

endmodule

>>> dv/sorted_label_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_label_table_tb: self-checking bench for the sorted label table
// Drives find, insert/upgrade and remove requests through the start/busy
// handshake and checks every response strobe against a behavioral table
// kept in step with each accepted request. It covers an empty table, a
// partly filled table with long shifts both ways, and a random run over a
// small address pool with bursty request timing.
// ----------------------------------------------------------------------------
module sorted_label_table_tb;

   localparam int          TABLE_DEPTH   = 1024;
   localparam int          POOL_SIZE     = 48;
   localparam int          FILL_ITEMS    = 240;
   localparam int          RANDOM_ITEMS  = 300;
   localparam int          REPORT_LIMIT  = 10;
   localparam logic [1:0]  MODE_UNUSED   = 2'd3;

   // Behavioral copy of the table and the queue of responses it predicts
   class label_table_scoreboard;
      logic [31:0]           key_tbl  [TABLE_DEPTH];
      logic [7:0]            type_tbl [TABLE_DEPTH];
      logic [7:0]            seg_tbl  [TABLE_DEPTH];
      int                    entry_count;
      int                    mismatch_count;
      slt_pkg::rsp_item_type pending_rsp [$];

      function new();
         entry_count    = 0;
         mismatch_count = 0;
      endfunction

      // Apply one accepted request to the table and queue its response
      function void note_request(slt_pkg::req_item_type item);
         int                    lo;
         int                    hi;
         int                    mid;
         int                    pos;
         bit                    present;
         slt_pkg::rsp_item_type rsp;
         lo = 0;
         hi = entry_count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_tbl[mid] < item.address) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         pos     = lo;
         present = (pos < entry_count) && (key_tbl[pos] == item.address);
         rsp     = '0;
         case (item.mode)
            slt_pkg::MODE_INSERT: begin
               if (present) begin
                  if (item.label_type[slt_pkg::TYPE_BITS-1:slt_pkg::CLASS_LSB] >
                      type_tbl[pos][slt_pkg::TYPE_BITS-1:slt_pkg::CLASS_LSB]) begin
                     type_tbl[pos] = item.label_type;
                     rsp.status    = slt_pkg::STATUS_UPGRADED;
                  end else begin
                     rsp.status = slt_pkg::STATUS_REUSED;
                  end
                  rsp.slot           = slt_pkg::SLOT_BITS'(pos);
                  rsp.stored_type    = type_tbl[pos];
                  rsp.stored_segment = seg_tbl[pos];
               end else if (entry_count >= TABLE_DEPTH) begin
                  rsp.status = slt_pkg::STATUS_FULL;
               end else begin
                  // open a hole at the sorted position
                  for (int i = entry_count; i > pos; i--) begin
                     key_tbl[i]  = key_tbl[i-1];
                     type_tbl[i] = type_tbl[i-1];
                     seg_tbl[i]  = seg_tbl[i-1];
                  end
                  key_tbl[pos]       = item.address;
                  type_tbl[pos]      = item.label_type;
                  seg_tbl[pos]       = item.segment;
                  entry_count++;
                  rsp.status         = slt_pkg::STATUS_INSERTED;
                  rsp.slot           = slt_pkg::SLOT_BITS'(pos);
                  rsp.stored_type    = item.label_type;
                  rsp.stored_segment = item.segment;
               end
            end
            slt_pkg::MODE_REMOVE: begin
               if (!present) begin
                  rsp.status = slt_pkg::STATUS_ABSENT;
               end else begin
                  rsp.status         = slt_pkg::STATUS_REMOVED;
                  rsp.slot           = slt_pkg::SLOT_BITS'(pos);
                  rsp.stored_type    = type_tbl[pos];
                  rsp.stored_segment = seg_tbl[pos];
                  // close the gap left by the removed entry
                  for (int i = pos; i + 1 < entry_count; i++) begin
                     key_tbl[i]  = key_tbl[i+1];
                     type_tbl[i] = type_tbl[i+1];
                     seg_tbl[i]  = seg_tbl[i+1];
                  end
                  entry_count--;
               end
            end
            default: begin
               // find, and the unused mode code, which acts as a find
               if (present) begin
                  rsp.status         = slt_pkg::STATUS_FOUND;
                  rsp.slot           = slt_pkg::SLOT_BITS'(pos);
                  rsp.stored_type    = type_tbl[pos];
                  rsp.stored_segment = seg_tbl[pos];
               end else begin
                  rsp.status = slt_pkg::STATUS_ABSENT;
               end
            end
         endcase
         rsp.occupancy = slt_pkg::OCC_BITS'(entry_count);
         pending_rsp.push_back(rsp);
      endfunction

      // Compare one response strobe with the oldest prediction
      function void check_response(slt_pkg::rsp_item_type got);
         slt_pkg::rsp_item_type want;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: response with nothing pending: %h", $realtime, got);
            end
            return;
         end
         want = pending_rsp.pop_front();
         if (got.status !== want.status || got.slot !== want.slot ||
             got.stored_type !== want.stored_type ||
             got.stored_segment !== want.stored_segment ||
             got.occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: mismatch exp st=%0d slot=%0d type=%h seg=%h occ=%0d",
                        $realtime, want.status, want.slot, want.stored_type,
                        want.stored_segment, want.occupancy);
               $display("%0t:          got st=%0d slot=%0d type=%h seg=%h occ=%0d",
                        $realtime, got.status, got.slot, got.stored_type,
                        got.stored_segment, got.occupancy);
            end
         end
      endfunction
   endclass

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  start    = 1'b0;
   slt_pkg::req_item_type req_data = '0;
   logic                  busy;
   logic                  rsp_valid;
   slt_pkg::rsp_item_type rsp_data;

   label_table_scoreboard table_sb;
   logic [31:0]           addr_pool [POOL_SIZE];

   sorted_label_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Present a request and hold it until the block takes it
   task automatic send_request(input slt_pkg::req_item_type item);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      table_sb.note_request(item);
   endtask

   task automatic send_fields(input logic [1:0] mode, input logic [31:0] address,
                              input logic [7:0] label_type, input logic [7:0] segment);
      slt_pkg::req_item_type item;
      item.mode       = mode;
      item.address    = address;
      item.label_type = label_type;
      item.segment    = segment;
      send_request(item);
   endtask

   // Drop start for a number of cycles
   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Hold off new requests until every predicted response is back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (table_sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Check each response strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         table_sb.check_response(rsp_data);
      end
   end

   initial begin
      #40_000_000;
      $display("sorted_label_table_tb: errors");
      $finish;
   end

   initial begin
      slt_pkg::req_item_type item;
      int                    sent;
      int                    burst_len;
      int                    pick;
      table_sb = new();
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) begin
         addr_pool[i] = $urandom;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // empty table, edge addresses, upgrade and reuse, middle, front and end removals
      send_fields(slt_pkg::MODE_FIND,   32'h0000_0000, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_fields(slt_pkg::MODE_INSERT, 32'h8000_0000, 8'h35, 8'hA5);
      send_fields(slt_pkg::MODE_INSERT, 32'h0000_0000, 8'hFF, 8'h00);
      send_fields(slt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 8'h00, 8'hFF);
      send_fields(slt_pkg::MODE_INSERT, 32'h8000_0000, 8'h4C, 8'h11);
      send_fields(slt_pkg::MODE_INSERT, 32'h8000_0000, 8'h4F, 8'h22);
      send_fields(slt_pkg::MODE_INSERT, 32'h8000_0000, 8'h2C, 8'h33);
      send_fields(slt_pkg::MODE_INSERT, 32'h0000_0000, 8'h0F, 8'h44);
      send_fields(slt_pkg::MODE_FIND,   32'h8000_0000, 8'h00, 8'h00);
      send_fields(MODE_UNUSED,          32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_fields(MODE_UNUSED,          32'h1234_5678, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_FIND,   32'h7FFF_FFFF, 8'h00, 8'h00);
      idle_for(3);
      send_fields(slt_pkg::MODE_REMOVE, 32'h8000_0000, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_REMOVE, 32'h0000_0000, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_INSERT, 32'h55AA_55AA, 8'hA0, 8'h5A);
      send_fields(slt_pkg::MODE_INSERT, 32'hAA55_AA55, 8'h0A, 8'hA5);
      drain_responses();

      // fill part of the table with ascending keys below the two stored ones
      sent = 0;
      while (sent < FILL_ITEMS) begin
         send_fields(slt_pkg::MODE_INSERT, 32'h0000_0100 + 32'(sent) * 16,
                     {4'h1, 4'($urandom)}, 8'($urandom));
         sent++;
      end

      // insert near the bottom, upgrade and reuse, long shifts both ways
      send_fields(slt_pkg::MODE_INSERT, 32'h0000_0108, 8'h77, 8'h77);
      send_fields(slt_pkg::MODE_INSERT, 32'h0000_0100, 8'hF3, 8'h66);
      send_fields(slt_pkg::MODE_INSERT, 32'h0000_0100, 8'h80, 8'h66);
      send_fields(slt_pkg::MODE_FIND,   32'hAA55_AA55, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_REMOVE, 32'h0000_0100, 8'h00, 8'h00);
      send_fields(slt_pkg::MODE_INSERT, 32'h0000_0100, 8'h5E, 8'hC3);
      send_fields(slt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 8'h99, 8'h99);
      drain_responses();

      // random requests in bursts over a small address pool
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 24);
         for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
               item.mode = slt_pkg::MODE_INSERT;
            end else if (pick <= 5) begin
               item.mode = slt_pkg::MODE_FIND;
            end else if (pick <= 8) begin
               item.mode = slt_pkg::MODE_REMOVE;
            end else begin
               item.mode = MODE_UNUSED;
            end
            if ($urandom_range(0, 99) < 85) begin
               item.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
               item.address = $urandom;
            end
            item.label_type = 8'($urandom);
            item.segment    = 8'($urandom);
            send_request(item);
            sent++;
            if (sent == RANDOM_ITEMS / 2) begin
               drain_responses();
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            idle_for($urandom_range(1, 40));
         end
      end

      // let the last responses arrive
      drain_responses();
      repeat (64) @(posedge clock);
      if (table_sb.mismatch_count == 0 && table_sb.pending_rsp.size() == 0) begin
         $display("sorted_label_table_tb: clean");
      end else begin
         $display("sorted_label_table_tb: errors");
      end
      $finish;
   end

endmodule
